FILE: design/ipv4_masked_route_lookup_core_defines.svh
// Assertion macros used by the checker file.
`ifndef IPV4_MASKED_ROUTE_LOOKUP_CORE_DEFINES_SVH
`define IPV4_MASKED_ROUTE_LOOKUP_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define IPV4RL_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ipv4rl check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define IPV4RL_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ipv4rl check failed");

`endif

FILE: design/ipv4rl_pkg.sv
`timescale 1ns / 1ps
package ipv4rl_pkg;

  localparam int ADDR_W          = 32;
  localparam int PORT_W          = 8;
  localparam int KEY_W           = 6;
  localparam int MODE_W          = 2;
  localparam int TABLE_DEPTH_DEF = 64;

  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] mask;
    logic              use_dst;
    logic [PORT_W-1:0] port;
    logic [KEY_W-1:0]  key;
  } rule_t;

  typedef struct packed {
    logic              hit;
    logic [PORT_W-1:0] port;
  } scan_t;

  typedef struct packed {
    logic insert;
    logic compare;
    logic shift;
  } cell_cmd_t;

  // adder tree, five levels
  function automatic logic [KEY_W-1:0] popcount(input logic [ADDR_W-1:0] v);
    logic [1:0] l1 [16];
    logic [2:0] l2 [8];
    logic [3:0] l3 [4];
    logic [4:0] l4 [2];
    for (int i = 0; i < 16; i++) l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
    for (int i = 0; i < 8; i++)  l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
    for (int i = 0; i < 4; i++)  l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
    for (int i = 0; i < 2; i++)  l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
    return {1'b0, l4[0]} + {1'b0, l4[1]};
  endfunction

endpackage

FILE: design/ipv4rl_cell.sv
`timescale 1ns / 1ps
module ipv4rl_cell (
  input  logic                            clk,
  input  ipv4rl_pkg::cell_cmd_t           cmd,
  input  logic                            valid,
  input  ipv4rl_pkg::rule_t               new_rule,
  input  ipv4rl_pkg::rule_t               prev_rule,
  input  logic                            prev_moving,
  output ipv4rl_pkg::rule_t               rule,
  output logic                            moving,
  input  logic [ipv4rl_pkg::ADDR_W-1:0]   pkt_src_addr,
  input  logic [ipv4rl_pkg::ADDR_W-1:0]   pkt_dst_addr,
  input  logic [ipv4rl_pkg::PORT_W-1:0]   arrival_port,
  input  ipv4rl_pkg::scan_t               scan_in,
  output ipv4rl_pkg::scan_t               scan_out
);

  ipv4rl_pkg::rule_t                  rule_q;
  ipv4rl_pkg::scan_t                  scan_q;
  logic [ipv4rl_pkg::ADDR_W-1:0]      sel_addr;
  logic                               match;

  // entry slides one place down when the new rule outranks it
  assign moving = valid && (new_rule.key > rule_q.key);

  assign sel_addr = rule_q.use_dst ? pkt_dst_addr : pkt_src_addr;
  assign match    = (((sel_addr ^ rule_q.addr) & rule_q.mask) == '0) &&
                    (rule_q.port != arrival_port);

  always_ff @(posedge clk) begin
    if (cmd.insert && (!valid || moving)) begin
      rule_q <= prev_moving ? prev_rule : new_rule;
    end
    if (cmd.compare) begin
      scan_q <= '{hit: match, port: rule_q.port};
    end else if (cmd.shift) begin
      scan_q <= scan_in;
    end
  end

  assign rule     = rule_q;
  assign scan_out = scan_q;

endmodule

FILE: design/ipv4_masked_route_lookup_core.sv
`timescale 1ns / 1ps
// Masked IPv4 route table. One input channel (in_valid/in_ready) carries a
// transaction with a mode: clear, insert a rule, or look up a packet. Each
// transaction gives exactly one result transaction on out_valid/out_ready.
// Rules sit in a row of cells kept in descending mask-popcount order; an
// insert shifts all lower-ranked cells down by one place in the same cycle.
// A lookup compares all cells at once, then the per-cell hit flags shift
// toward cell 0 one place per cycle until the first hit or the rule count.
// From accept, clear, non-IPv4 lookup and undefined mode go from the CALC
// state straight to FIN; an insert passes through APPLY and a lookup
// through SCAN, whose walk over the cell row ends at the first hit or at
// the rule count. One transaction is worked at a time; in_ready returns
// the cycle after the result is loaded.
// The result register decouples the sides: the next transaction is taken
// while a result waits, and it stalls only at its own result load until
// out_ready frees the register.
// Reset (rst, synchronous) empties the table and drops any pending result.
module ipv4_masked_route_lookup_core #(
  parameter int TABLE_DEPTH = ipv4rl_pkg::TABLE_DEPTH_DEF,
  localparam int CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ipv4rl_pkg::MODE_W-1:0]       mode,
  input  logic [ipv4rl_pkg::ADDR_W-1:0]       rule_addr,
  input  logic [ipv4rl_pkg::ADDR_W-1:0]       rule_mask,
  input  logic                                rule_use_dst,
  input  logic [ipv4rl_pkg::PORT_W-1:0]       rule_port,
  input  logic [ipv4rl_pkg::ADDR_W-1:0]       pkt_src_addr,
  input  logic [ipv4rl_pkg::ADDR_W-1:0]       pkt_dst_addr,
  input  logic [ipv4rl_pkg::PORT_W-1:0]       arrival_port,
  input  logic                                is_ipv4,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                hit,
  output logic [ipv4rl_pkg::PORT_W-1:0]       egress_port,
  output logic                                insert_dropped,
  output logic [CNT_W-1:0]                    rule_count
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CALC  = 5'b00010,
    S_APPLY = 5'b00100,
    S_SCAN  = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  state_t                              state;
  logic [ipv4rl_pkg::MODE_W-1:0]       op_mode;
  logic [ipv4rl_pkg::ADDR_W-1:0]       op_addr;
  logic [ipv4rl_pkg::ADDR_W-1:0]       op_mask;
  logic                                op_use_dst;
  logic [ipv4rl_pkg::PORT_W-1:0]       op_port;
  logic [ipv4rl_pkg::ADDR_W-1:0]       op_src;
  logic [ipv4rl_pkg::ADDR_W-1:0]       op_dst;
  logic [ipv4rl_pkg::PORT_W-1:0]       op_arrival;
  logic                                op_ipv4;
  logic [ipv4rl_pkg::KEY_W-1:0]        key;
  logic [CNT_W-1:0]                    stored_rules;
  logic [CNT_W-1:0]                    scan_idx;
  logic                                res_hit;
  logic [ipv4rl_pkg::PORT_W-1:0]       res_port;
  logic                                res_drop;
  logic                                full;
  logic                                out_free;

  ipv4rl_pkg::cell_cmd_t               cmd;
  ipv4rl_pkg::rule_t                   new_rule;
  ipv4rl_pkg::rule_t                   rules       [TABLE_DEPTH];
  ipv4rl_pkg::rule_t                   prev_rule   [TABLE_DEPTH];
  ipv4rl_pkg::scan_t                   scans       [TABLE_DEPTH];
  ipv4rl_pkg::scan_t                   scan_in     [TABLE_DEPTH];
  logic                                moving      [TABLE_DEPTH];
  logic                                prev_moving [TABLE_DEPTH];
  logic                                valid       [TABLE_DEPTH];

  assign in_ready = (state == S_IDLE);
  assign full     = (stored_rules == CNT_W'(TABLE_DEPTH));
  assign out_free = !out_valid || out_ready;
  assign new_rule = '{addr: op_addr, mask: op_mask, use_dst: op_use_dst,
                      port: op_port, key: key};

  always_comb begin
    cmd = '0;
    unique case (state)
      S_CALC:  cmd.compare = (op_mode == ipv4rl_pkg::MODE_LOOKUP) && op_ipv4;
      S_APPLY: cmd.insert  = !full;
      S_SCAN:  cmd.shift   = (scan_idx != stored_rules) && !scans[0].hit;
      default: cmd = '0;
    endcase
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    assign valid[g] = stored_rules > CNT_W'(g);
    if (g == 0) begin : g_head
      assign prev_rule[g]   = '0;
      assign prev_moving[g] = 1'b0;
    end else begin : g_body
      assign prev_rule[g]   = rules[g-1];
      assign prev_moving[g] = moving[g-1];
    end
    if (g == TABLE_DEPTH - 1) begin : g_tail
      assign scan_in[g] = '0;
    end else begin : g_link
      assign scan_in[g] = scans[g+1];
    end

    ipv4rl_cell u_cell (
      .clk          (clk),
      .cmd          (cmd),
      .valid        (valid[g]),
      .new_rule     (new_rule),
      .prev_rule    (prev_rule[g]),
      .prev_moving  (prev_moving[g]),
      .rule         (rules[g]),
      .moving       (moving[g]),
      .pkt_src_addr (op_src),
      .pkt_dst_addr (op_dst),
      .arrival_port (op_arrival),
      .scan_in      (scan_in[g]),
      .scan_out     (scans[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      stored_rules <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_CALC;
          end
        end
        S_CALC: begin
          unique case (op_mode)
            ipv4rl_pkg::MODE_CLEAR: begin
              stored_rules <= '0;
              state        <= S_FIN;
            end
            ipv4rl_pkg::MODE_INSERT: state <= S_APPLY;
            ipv4rl_pkg::MODE_LOOKUP: state <= op_ipv4 ? S_SCAN : S_FIN;
            default:                 state <= S_FIN;
          endcase
        end
        S_APPLY: begin
          if (!full) begin
            stored_rules <= stored_rules + CNT_W'(1);
          end
          state <= S_FIN;
        end
        S_SCAN: begin
          if (scan_idx == stored_rules || scans[0].hit) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_mode    <= mode;
      op_addr    <= rule_addr;
      op_mask    <= rule_mask;
      op_use_dst <= rule_use_dst;
      op_port    <= rule_port;
      op_src     <= pkt_src_addr;
      op_dst     <= pkt_dst_addr;
      op_arrival <= arrival_port;
      op_ipv4    <= is_ipv4;
      res_hit    <= 1'b0;
      res_port   <= '0;
      res_drop   <= 1'b0;
    end
    if (state == S_CALC) begin
      key      <= ipv4rl_pkg::popcount(op_mask);
      scan_idx <= '0;
    end
    if (state == S_APPLY && full) begin
      res_drop <= 1'b1;
    end
    if (state == S_SCAN) begin
      if (scan_idx != stored_rules) begin
        if (scans[0].hit) begin
          res_hit  <= 1'b1;
          res_port <= scans[0].port;
        end else begin
          scan_idx <= scan_idx + CNT_W'(1);
        end
      end
    end
    if (state == S_FIN && out_free) begin
      hit            <= res_hit;
      egress_port    <= res_port;
      insert_dropped <= res_drop;
      rule_count     <= stored_rules;
    end
  end

endmodule

FILE: design/ipv4rl_checker.sv
`timescale 1ns / 1ps
`include "ipv4_masked_route_lookup_core_defines.svh"
module ipv4rl_checker #(
  parameter int TABLE_DEPTH = ipv4rl_pkg::TABLE_DEPTH_DEF,
  parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           hit,
  input logic [ipv4rl_pkg::PORT_W-1:0]  egress_port,
  input logic                           insert_dropped,
  input logic [CNT_W-1:0]               rule_count
);

  `IPV4RL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `IPV4RL_ASSERT_IMPL(a_count_bound, out_valid, rule_count <= CNT_W'(TABLE_DEPTH))
  `IPV4RL_ASSERT_IMPL(a_miss_port_zero, out_valid && !hit, egress_port == '0)
  `IPV4RL_ASSERT_IMPL(a_drop_only_full, out_valid && insert_dropped, !hit && rule_count == CNT_W'(TABLE_DEPTH))

endmodule

bind ipv4_masked_route_lookup_core ipv4rl_checker #(
  .TABLE_DEPTH (TABLE_DEPTH),
  .CNT_W       (CNT_W)
) u_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .hit            (hit),
  .egress_port    (egress_port),
  .insert_dropped (insert_dropped),
  .rule_count     (rule_count)
);
